@@ hdl/mau_pkg.sv @@
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Field widths, action codes, internal command words and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

   localparam int MOD_WIDTH      = 31;
   localparam int FIELD_WIDTH    = 31;
   localparam int ACTION_WIDTH   = 3;
   localparam int CNT_WIDTH      = $clog2(MOD_WIDTH + 1);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(32'd1000000007);
   localparam logic [MOD_WIDTH-1:0] MOD_ONE   = MOD_WIDTH'(1);
   localparam logic [MOD_WIDTH-1:0] MOD_TWO   = MOD_WIDTH'(2);
   localparam logic [CNT_WIDTH-1:0] CNT_LOAD  = CNT_WIDTH'(MOD_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST  = CNT_WIDTH'(1);

   localparam logic [CSR_ADDR_WIDTH-3:0] REG_MODULUS = '0;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_INV = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      UOP_MUL = 2'd0,
      UOP_ADD = 2'd1,
      UOP_SUB = 2'd2
   } unit_op_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [FIELD_WIDTH-1:0]  operand_a;
      logic [FIELD_WIDTH-1:0]  operand_b;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] residue;
      logic                   a_less_than_b;
      logic                   a_equals_b;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      unit_op_type          op;
      logic [MOD_WIDTH-1:0] x;
      logic [MOD_WIDTH-1:0] y;
      logic [MOD_WIDTH-1:0] m;
   } unit_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [MOD_WIDTH-1:0] result;
   } unit_rsp_type;

endpackage

`default_nettype wire

@@ hdl/mau_modmul.sv @@
// ----------------------------------------------------------------------------
// mau_modmul: shared modular arithmetic unit
// Bit-serial interleaved modular multiply (one multiplier bit per cycle),
// plus modular add and subtract of reduced operands, with the result registered in the cycle after the start.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_modmul (
   input  logic                  clock,
   input  logic                  reset,
   input  mau_pkg::unit_cmd_type cmd,
   output mau_pkg::unit_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mau_pkg::MOD_WIDTH-1:0]   x_ff, x_in;
   logic [mau_pkg::MOD_WIDTH-1:0]   y_ff, y_in;
   logic [mau_pkg::MOD_WIDTH-1:0]   m_ff, m_in;
   logic [mau_pkg::MOD_WIDTH-1:0]   acc_ff, acc_in;
   logic [mau_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;

   logic [mau_pkg::MOD_WIDTH+1:0]   step_sum, step_m1, step_m2;
   logic [mau_pkg::MOD_WIDTH+1:0]   step_d1, step_d2;
   logic [mau_pkg::MOD_WIDTH:0]     add_sum, add_diff, sub_diff;
   logic [mau_pkg::MOD_WIDTH-1:0]   add_res, sub_res;

   always_comb begin
      step_m1  = {2'b00, m_ff};
      step_m2  = {1'b0, m_ff, 1'b0};
      step_sum = {1'b0, acc_ff, 1'b0}
               + (x_ff[mau_pkg::MOD_WIDTH-1] ? {2'b00, y_ff} : '0);
      step_d1  = step_sum - step_m1;
      step_d2  = step_sum - step_m2;

      add_sum  = {1'b0, cmd.x} + {1'b0, cmd.y};
      add_diff = add_sum - {1'b0, cmd.m};
      add_res  = (add_sum >= {1'b0, cmd.m}) ? add_diff[mau_pkg::MOD_WIDTH-1:0]
                                            : add_sum[mau_pkg::MOD_WIDTH-1:0];
      sub_diff = {1'b0, cmd.x} - {1'b0, cmd.y};
      sub_res  = sub_diff[mau_pkg::MOD_WIDTH] ? sub_diff[mau_pkg::MOD_WIDTH-1:0] + cmd.m
                                              : sub_diff[mau_pkg::MOD_WIDTH-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         unique case (cmd.op)
            mau_pkg::UOP_MUL: begin
               x_in    = cmd.x;
               y_in    = cmd.y;
               m_in    = cmd.m;
               acc_in  = '0;
               cnt_in  = mau_pkg::CNT_LOAD;
               busy_in = 1'b1;
            end
            mau_pkg::UOP_ADD: begin
               acc_in  = add_res;
               done_in = 1'b1;
            end
            mau_pkg::UOP_SUB: begin
               acc_in  = sub_res;
               done_in = 1'b1;
            end
            default: begin
               acc_in  = '0;
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         priority if (step_sum >= step_m2) begin
            acc_in = step_d2[mau_pkg::MOD_WIDTH-1:0];
         end else if (step_sum >= step_m1) begin
            acc_in = step_d1[mau_pkg::MOD_WIDTH-1:0];
         end else begin
            acc_in = step_sum[mau_pkg::MOD_WIDTH-1:0];
         end
         x_in   = x_ff << 1;
         cnt_in = cnt_ff - mau_pkg::CNT_LAST;
         if (cnt_ff == mau_pkg::CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

`default_nettype wire

@@ hdl/mau_csr.sv @@
// ----------------------------------------------------------------------------
// mau_csr: configuration register block
// APB-style access to the modulus register.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mau_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mau_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [mau_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output logic [mau_pkg::MOD_WIDTH-1:0]        modulus
);

   logic [mau_pkg::MOD_WIDTH-1:0]      modulus_ff, modulus_in;
   logic                               hit_modulus;
   logic [mau_pkg::CSR_DATA_WIDTH-1:0] modulus_ext;

   always_comb begin
      hit_modulus = (csr_paddr[mau_pkg::CSR_ADDR_WIDTH-1:2] == mau_pkg::REG_MODULUS);
      modulus_in  = modulus_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_modulus) begin
         modulus_in = csr_pwdata[mau_pkg::MOD_WIDTH-1:0];
      end
      modulus_ext = '0;
      modulus_ext[mau_pkg::MOD_WIDTH-1:0] = modulus_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mau_pkg::MOD_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign csr_prdata = hit_modulus ? modulus_ext : '0;
   assign csr_pready = 1'b1;
   assign modulus    = modulus_ff;

endmodule

`default_nettype wire

@@ hdl/modular_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_core: modular arithmetic over a configurable prime
// Add, subtract, multiply, divide and inverse modulo the modulus register,
// with compare flags on the reduced operands.
// ----------------------------------------------------------------------------
// One word is worked at a time. Both operands are first reduced through the
// bit-serial modular multiplier, one pass each. Divide and inverse raise a
// value to the power modulus minus two by square-and-multiply; every set
// exponent bit costs two passes of the multiplier and every clear bit one.
// The multiplier handles one operand bit per cycle. A finished word waits in
// the output register while the next word enters.
`default_nettype none

module modular_arithmetic_unit_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mau_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mau_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mau_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mau_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [mau_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_RED_A    = 9'b000000010,
      ST_RED_B    = 9'b000000100,
      ST_DISPATCH = 9'b000001000,
      ST_POW      = 9'b000010000,
      ST_POW_MUL  = 9'b000100000,
      ST_POW_SQR  = 9'b001000000,
      ST_FINAL    = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type                            state_ff, state_in;
   logic [mau_pkg::ACTION_WIDTH-1:0]     action_ff, action_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        b_raw_ff, b_raw_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        m_item_ff, m_item_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        a_ff, a_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        b_ff, b_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        base_ff, base_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        acc_ff, acc_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        e_ff, e_in;
   logic [mau_pkg::MOD_WIDTH-1:0]        res_ff, res_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   mau_pkg::rsp_type                     rsp_data_ff, rsp_data_in;

   logic [mau_pkg::MOD_WIDTH-1:0]        modulus;
   logic                                 req_accept;
   logic                                 mod_small;
   logic [mau_pkg::FIELD_WIDTH-1:0]      res_ext;
   mau_pkg::unit_cmd_type                unit_cmd;
   mau_pkg::unit_rsp_type                unit_rsp;

   mau_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .modulus     (modulus)
   );

   mau_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .rsp   (unit_rsp)
   );

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign mod_small  = (modulus[mau_pkg::MOD_WIDTH-1:1] == '0);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      b_raw_in     = b_raw_ff;
      m_item_in    = m_item_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      res_ext      = '0;
      res_ext[mau_pkg::MOD_WIDTH-1:0] = res_ff;

      unit_cmd.start = 1'b0;
      unit_cmd.op    = mau_pkg::UOP_MUL;
      unit_cmd.x     = '0;
      unit_cmd.y     = '0;
      unit_cmd.m     = m_item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_data.action;
               b_raw_in  = req_data.operand_b[mau_pkg::MOD_WIDTH-1:0];
               m_item_in = modulus;
               if (mod_small) begin
                  a_in     = '0;
                  b_in     = '0;
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  unit_cmd.start = 1'b1;
                  unit_cmd.x     = req_data.operand_a[mau_pkg::MOD_WIDTH-1:0];
                  unit_cmd.y     = mau_pkg::MOD_ONE;
                  unit_cmd.m     = modulus;
                  state_in       = ST_RED_A;
               end
            end
         end
         ST_RED_A: begin
            if (unit_rsp.done) begin
               a_in           = unit_rsp.result;
               unit_cmd.start = 1'b1;
               unit_cmd.x     = b_raw_ff;
               unit_cmd.y     = mau_pkg::MOD_ONE;
               state_in       = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (unit_rsp.done) begin
               b_in     = unit_rsp.result;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            acc_in     = mau_pkg::MOD_ONE;
            e_in       = m_item_ff - mau_pkg::MOD_TWO;
            unit_cmd.x = a_ff;
            unit_cmd.y = b_ff;
            unique case (action_ff)
               mau_pkg::ACT_ADD: begin
                  unit_cmd.start = 1'b1;
                  unit_cmd.op    = mau_pkg::UOP_ADD;
                  state_in       = ST_FINAL;
               end
               mau_pkg::ACT_SUB: begin
                  unit_cmd.start = 1'b1;
                  unit_cmd.op    = mau_pkg::UOP_SUB;
                  state_in       = ST_FINAL;
               end
               mau_pkg::ACT_MUL: begin
                  unit_cmd.start = 1'b1;
                  state_in       = ST_FINAL;
               end
               mau_pkg::ACT_DIV: begin
                  base_in = b_ff;
                  if (b_ff == '0) begin
                     res_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_POW;
                  end
               end
               mau_pkg::ACT_INV: begin
                  base_in = a_ff;
                  if (a_ff == '0) begin
                     res_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_POW;
                  end
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_POW: begin
            unit_cmd.start = 1'b1;
            priority if (e_ff == '0) begin
               if (action_ff == mau_pkg::ACT_DIV) begin
                  unit_cmd.x = a_ff;
                  unit_cmd.y = acc_ff;
                  state_in   = ST_FINAL;
               end else begin
                  unit_cmd.start = 1'b0;
                  res_in         = acc_ff;
                  state_in       = ST_DONE;
               end
            end else if (e_ff[0]) begin
               unit_cmd.x = acc_ff;
               unit_cmd.y = base_ff;
               state_in   = ST_POW_MUL;
            end else begin
               unit_cmd.x = base_ff;
               unit_cmd.y = base_ff;
               state_in   = ST_POW_SQR;
            end
         end
         ST_POW_MUL: begin
            if (unit_rsp.done) begin
               acc_in         = unit_rsp.result;
               unit_cmd.start = 1'b1;
               unit_cmd.x     = base_ff;
               unit_cmd.y     = base_ff;
               state_in       = ST_POW_SQR;
            end
         end
         ST_POW_SQR: begin
            if (unit_rsp.done) begin
               base_in  = unit_rsp.result;
               e_in     = e_ff >> 1;
               state_in = ST_POW;
            end
         end
         ST_FINAL: begin
            if (unit_rsp.done) begin
               res_in   = unit_rsp.result;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.residue       = res_ext;
               rsp_data_in.a_less_than_b = (a_ff < b_ff);
               rsp_data_in.a_equals_b    = (a_ff == b_ff);
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff   <= action_in;
      b_raw_ff    <= b_raw_in;
      m_item_ff   <= m_item_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      e_ff        <= e_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start the sequencer");

   a_unit_result_reduced: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (unit_rsp.result < m_item_ff))
      else $error("arithmetic unit result not below modulus");

   a_unit_done_expected: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == ST_RED_A || state_ff == ST_RED_B ||
                         state_ff == ST_POW_MUL || state_ff == ST_POW_SQR ||
                         state_ff == ST_FINAL))
      else $error("arithmetic unit finished while sequencer was not waiting");

endmodule

`default_nettype wire

@@ sim/tb_modular_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit_core: self-checking bench of the modular unit
// Runs a directed table and then random words over a range of modulus
// settings, from 0 and 1 up to 2^31-1. Each word is checked against a local
// model of add, subtract, multiply, Fermat divide and inverse or a result
// typed in the table, flags included. The sender idles and the receiver
// stalls at random, and once for a long stretch. A watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_modular_arithmetic_unit_core;

   localparam logic [mau_pkg::ACTION_WIDTH-1:0]   ACT_SPARE_FIRST = 3'd5;
   localparam logic [mau_pkg::ACTION_WIDTH-1:0]   ACT_SPARE_LAST  = 3'd7;
   localparam logic [mau_pkg::CSR_ADDR_WIDTH-1:0] ADDR_MODULUS    =
      {mau_pkg::REG_MODULUS, 2'b00};
   localparam logic [mau_pkg::CSR_ADDR_WIDTH-1:0] ADDR_SPARE      = 3'd4;
   localparam logic [mau_pkg::MOD_WIDTH-1:0]      FIELD_MAX       = '1;
   localparam int STUCK_LIMIT    = 20000;
   localparam int HOLD_CYCLES    = 500;
   localparam int HOLD_AT        = 60;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TAIL_CYCLES    = 2200;
   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_COUNT    = 11;

   typedef struct packed {
      logic [mau_pkg::MOD_WIDTH-1:0]    modulus;
      logic [mau_pkg::ACTION_WIDTH-1:0] action;
      logic [mau_pkg::FIELD_WIDTH-1:0]  a;
      logic [mau_pkg::FIELD_WIDTH-1:0]  b;
      logic                             typed;
      mau_pkg::rsp_type                 want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mau_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mau_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [mau_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [mau_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [mau_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   logic [mau_pkg::MOD_WIDTH-1:0] modulus_setting = mau_pkg::MOD_RESET;
   mau_pkg::rsp_type expected_results [$];
   int mismatch_count = 0;
   int words_accepted = 0;
   int results_seen = 0;
   int modulus_writes = 0;
   int action_seen [8];
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stuck_cycles = 0;
   mau_pkg::rsp_type want_rsp;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_ADD, 31'd0, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b1}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_SUB, 31'd0, 31'd1, 1'b1,
        '{31'd1000000006, 1'b1, 1'b0}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_ADD, 31'd1000000006, 31'd1, 1'b1,
        '{31'd0, 1'b0, 1'b0}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_MUL, 31'd1000000006, 31'd1000000006, 1'b1,
        '{31'd1, 1'b0, 1'b1}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_INV, 31'd0, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b1}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_INV, 31'd1, 31'd0, 1'b1, '{31'd1, 1'b0, 1'b0}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_DIV, 31'd5, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b0}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_ADD, 31'd1000000007, 31'd0, 1'b1,
        '{31'd0, 1'b0, 1'b1}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_ADD, FIELD_MAX, FIELD_MAX, 1'b0, '0},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_MUL, FIELD_MAX, 31'd12345, 1'b0, '0},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_DIV, FIELD_MAX, 31'd3, 1'b0, '0},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_DIV, 31'd1000000006, 31'd1000000006, 1'b1,
        '{31'd1, 1'b0, 1'b1}},
      '{mau_pkg::MOD_RESET, ACT_SPARE_FIRST, 31'd3, 31'd4, 1'b1, '{31'd0, 1'b1, 1'b0}},
      '{mau_pkg::MOD_RESET, ACT_SPARE_LAST, 31'd9, 31'd9, 1'b1, '{31'd0, 1'b0, 1'b1}},
      '{mau_pkg::MOD_RESET, mau_pkg::ACT_INV, 31'd2, 31'd0, 1'b0, '0},
      '{mau_pkg::MOD_TWO, mau_pkg::ACT_INV, 31'd1, 31'd0, 1'b1, '{31'd1, 1'b0, 1'b0}},
      '{mau_pkg::MOD_TWO, mau_pkg::ACT_ADD, FIELD_MAX, 31'd1, 1'b1, '{31'd0, 1'b0, 1'b1}},
      '{mau_pkg::MOD_TWO, mau_pkg::ACT_INV, 31'd2, 31'd3, 1'b1, '{31'd0, 1'b1, 1'b0}},
      '{31'd15, mau_pkg::ACT_INV, 31'd2, 31'd0, 1'b1, '{31'd2, 1'b0, 1'b0}},
      '{31'd15, mau_pkg::ACT_DIV, 31'd3, 31'd6, 1'b0, '0},
      '{FIELD_MAX, mau_pkg::ACT_SUB, 31'd0, FIELD_MAX - 31'd1, 1'b1,
        '{31'd1, 1'b1, 1'b0}},
      '{FIELD_MAX, mau_pkg::ACT_INV, FIELD_MAX - 31'd1, 31'd0, 1'b1,
        '{FIELD_MAX - 31'd1, 1'b0, 1'b0}},
      '{FIELD_MAX, mau_pkg::ACT_MUL, FIELD_MAX, 31'd5, 1'b1, '{31'd0, 1'b1, 1'b0}},
      '{31'd0, mau_pkg::ACT_ADD, 31'd5, 31'd9, 1'b1, '{31'd0, 1'b0, 1'b1}},
      '{mau_pkg::MOD_ONE, mau_pkg::ACT_INV, FIELD_MAX, 31'd0, 1'b1, '{31'd0, 1'b0, 1'b1}}
   };

   logic [mau_pkg::CSR_DATA_WIDTH-1:0] phase_word [PHASE_COUNT];
   int phase_items [PHASE_COUNT];

   modular_arithmetic_unit_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned fermat_inverse_of(longint unsigned value,
                                                          longint unsigned m);
      longint unsigned base;
      longint unsigned acc;
      longint unsigned e;
      base = value;
      acc = 1 % m;
      e = m - 2;
      if (value == 0) return 0;
      while (e != 0) begin
         if (e[0]) acc = (acc * base) % m;
         base = (base * base) % m;
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic mau_pkg::rsp_type modular_result(
      logic [mau_pkg::ACTION_WIDTH-1:0] action,
      logic [mau_pkg::FIELD_WIDTH-1:0]  a_in,
      logic [mau_pkg::FIELD_WIDTH-1:0]  b_in,
      logic [mau_pkg::MOD_WIDTH-1:0]    m_in);
      longint unsigned m;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      mau_pkg::rsp_type result;
      m = m_in;
      a = a_in;
      b = b_in;
      r = 0;
      if (m < 2) begin
         a = 0;
         b = 0;
      end else begin
         a = a % m;
         b = b % m;
         case (action)
            mau_pkg::ACT_ADD: r = (a + b) % m;
            mau_pkg::ACT_SUB: r = (a + m - b) % m;
            mau_pkg::ACT_MUL: r = (a * b) % m;
            mau_pkg::ACT_DIV: r = (a * fermat_inverse_of(b, m)) % m;
            mau_pkg::ACT_INV: r = fermat_inverse_of(a, m);
            default: r = 0;
         endcase
      end
      result.residue = mau_pkg::FIELD_WIDTH'(r);
      result.a_less_than_b = (a < b);
      result.a_equals_b = (a == b);
      return result;
   endfunction

   function automatic logic [mau_pkg::FIELD_WIDTH-1:0] pick_operand(
      logic [mau_pkg::MOD_WIDTH-1:0] m);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return mau_pkg::FIELD_WIDTH'($urandom);
      if (roll < 65) return (m == 0) ? '0 : mau_pkg::FIELD_WIDTH'($urandom % m);
      if (roll < 85) begin
         case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'd1;
            2: return m - 31'd1;
            3: return m;
            4: return m + 31'd1;
            default: return FIELD_MAX;
         endcase
      end
      return mau_pkg::FIELD_WIDTH'($urandom_range(0, 15));
   endfunction

   function automatic logic [mau_pkg::ACTION_WIDTH-1:0] pick_action();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return mau_pkg::ACT_ADD;
      if (roll < 50) return mau_pkg::ACT_SUB;
      if (roll < 72) return mau_pkg::ACT_MUL;
      if (roll < 82) return mau_pkg::ACT_DIV;
      if (roll < 92) return mau_pkg::ACT_INV;
      return mau_pkg::ACTION_WIDTH'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
   endfunction

   // write a register, then read the modulus back
   task automatic write_register(input logic [mau_pkg::CSR_ADDR_WIDTH-1:0] addr,
                                 input logic [mau_pkg::CSR_DATA_WIDTH-1:0] data);
      logic [mau_pkg::CSR_DATA_WIDTH-1:0] read_word;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_MODULUS) begin
         modulus_setting = data[mau_pkg::MOD_WIDTH-1:0];
         modulus_writes++;
      end
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_MODULUS;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      read_word = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (read_word[mau_pkg::MOD_WIDTH-1:0] !== modulus_setting) begin
         $display("%0t: modulus readback mismatch: expected %h actual %h",
                  $time, modulus_setting, read_word[mau_pkg::MOD_WIDTH-1:0]);
         mismatch_count++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_word(input logic [mau_pkg::ACTION_WIDTH-1:0] action,
                            input logic [mau_pkg::FIELD_WIDTH-1:0] a,
                            input logic [mau_pkg::FIELD_WIDTH-1:0] b,
                            input logic typed,
                            input mau_pkg::rsp_type typed_rsp);
      mau_pkg::req_type word;
      word.action = action;
      word.operand_a = a;
      word.operand_b = b;
      if (!(words_accepted >= 900 && words_accepted < 1150) &&
          $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(typed ? typed_rsp
                                       : modular_result(action, a, b, modulus_setting));
      words_accepted++;
      action_seen[action]++;
   endtask

   task automatic report_field(input string field,
                               input logic [mau_pkg::FIELD_WIDTH-1:0] want,
                               input logic [mau_pkg::FIELD_WIDTH-1:0] got);
      $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   // result side: check, then pick next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word: expected none actual %h/%b/%b",
                        $time, rsp_data.residue, rsp_data.a_less_than_b,
                        rsp_data.a_equals_b);
               mismatch_count++;
            end else begin
               want_rsp = expected_results.pop_front();
               if (rsp_data.residue !== want_rsp.residue)
                  report_field("residue", want_rsp.residue, rsp_data.residue);
               if (rsp_data.a_less_than_b !== want_rsp.a_less_than_b)
                  report_field("a_less_than_b", want_rsp.a_less_than_b,
                               rsp_data.a_less_than_b);
               if (rsp_data.a_equals_b !== want_rsp.a_equals_b)
                  report_field("a_equals_b", want_rsp.a_equals_b, rsp_data.a_equals_b);
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (results_seen >= 400 && results_seen < 700) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 15);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: watchdog: no handshake for %0d cycles", $time, STUCK_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      foreach (action_seen[i]) action_seen[i] = 0;
      phase_word = '{32'hFFFF_FFFF, 32'd2, 32'd3, 32'd65521, 32'd1000000007, 32'd251,
                     32'd15, 32'd0, 32'd1, 32'd0, 32'd0};
      phase_items = '{250, 150, 150, 250, 270, 200, 100, 50, 50, 100, 100};
      phase_word[9] = $urandom_range(3, 32'h7FFF_FFFF) | 32'd1;
      phase_word[10] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (directed_rows[r].modulus != modulus_setting) begin
            drain_results();
            write_register(ADDR_MODULUS, {1'b0, directed_rows[r].modulus});
         end
         send_word(directed_rows[r].action, directed_rows[r].a, directed_rows[r].b,
                   directed_rows[r].typed, directed_rows[r].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_results();
         if (p == 3) write_register(ADDR_SPARE, $urandom);
         write_register(ADDR_MODULUS, phase_word[p]);
         for (int i = 0; i < phase_items[p]; i++)
            send_word(pick_action(), pick_operand(modulus_setting),
                      pick_operand(modulus_setting), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d words over %0d modulus settings: add %0d sub %0d mul %0d",
               words_accepted, modulus_writes, action_seen[mau_pkg::ACT_ADD],
               action_seen[mau_pkg::ACT_SUB], action_seen[mau_pkg::ACT_MUL]);
      $display("div %0d inv %0d unused %0d, %0d results checked, %0d errors",
               action_seen[mau_pkg::ACT_DIV], action_seen[mau_pkg::ACT_INV],
               action_seen[5] + action_seen[6] + action_seen[7], results_seen,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ modular_arithmetic_unit_core.f @@
hdl/mau_pkg.sv
hdl/mau_modmul.sv
hdl/mau_csr.sv
hdl/modular_arithmetic_unit_core.sv
sim/tb_modular_arithmetic_unit_core.sv
